>>> rtl/core/mmae_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmae_pkg
// shared widths, opcodes, status codes and alu command types of the
// memory-to-memory alu executor
// ----------------------------------------------------------------------------
package mmae_pkg;

   localparam int unsigned OPCODE_W   = 5;
   localparam int unsigned ADDR_W     = 10;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned WIU_W      = 11;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned STEP_W     = 5;

   localparam logic [WIU_W-1:0] WIU_RESET = 11'd1024;

   // register index carried by csr_paddr[2]
   localparam logic CSR_IDX_WORDS_IN_USE = 1'b0;

   localparam logic [OPCODE_W-1:0] OP_PAD   = 5'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD_C = 5'd1;
   localparam logic [OPCODE_W-1:0] OP_ADD_M = 5'd2;
   localparam logic [OPCODE_W-1:0] OP_SUB_C = 5'd3;
   localparam logic [OPCODE_W-1:0] OP_SUB_M = 5'd4;
   localparam logic [OPCODE_W-1:0] OP_MUL_C = 5'd5;
   localparam logic [OPCODE_W-1:0] OP_MUL_M = 5'd6;
   localparam logic [OPCODE_W-1:0] OP_DIV_C = 5'd7;
   localparam logic [OPCODE_W-1:0] OP_DIV_M = 5'd8;
   localparam logic [OPCODE_W-1:0] OP_MOD_C = 5'd9;
   localparam logic [OPCODE_W-1:0] OP_MOD_M = 5'd10;
   localparam logic [OPCODE_W-1:0] OP_MOV_C = 5'd11;
   localparam logic [OPCODE_W-1:0] OP_MOV_M = 5'd12;
   localparam logic [OPCODE_W-1:0] OP_EQ_C  = 5'd13;
   localparam logic [OPCODE_W-1:0] OP_EQ_M  = 5'd14;
   localparam logic [OPCODE_W-1:0] OP_JMP   = 5'd15;
   localparam logic [OPCODE_W-1:0] OP_JZ    = 5'd16;
   localparam logic [OPCODE_W-1:0] OP_JNZ   = 5'd17;
   localparam logic [OPCODE_W-1:0] OP_JEQ   = 5'd18;
   localparam logic [OPCODE_W-1:0] OP_PRINT = 5'd19;
   localparam logic [OPCODE_W-1:0] OP_EXIT  = 5'd20;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 3'd0,
      ST_PRINT = 3'd1,
      ST_JUMP  = 3'd2,
      ST_EXIT  = 3'd3,
      ST_DIVZ  = 3'd4,
      ST_RANGE = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      FN_ADD,
      FN_SUB,
      FN_MUL,
      FN_DIV,
      FN_MOD,
      FN_MOV,
      FN_EQ
   } alu_func_type;

   typedef struct packed {
      logic         start;
      alu_func_type func;
   } alu_cmd_type;

   typedef struct packed {
      logic done;
      logic div_zero;
   } alu_sts_type;

endpackage
`default_nettype wire

>>> rtl/core/mmae_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmae_ifs
// valid/ready channels for instruction beats and result beats
// ----------------------------------------------------------------------------
interface mmae_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [mmae_pkg::OPCODE_W-1:0]  opcode;
   logic        [mmae_pkg::ADDR_W-1:0]    dest_addr;
   logic        [mmae_pkg::ADDR_W-1:0]    src_addr;
   logic        [mmae_pkg::ADDR_W-1:0]    src2_addr;
   logic signed [mmae_pkg::DATA_W-1:0]    immediate;
   logic        [mmae_pkg::DATA_W-1:0]    jump_offset;

   modport source (
      output valid, opcode, dest_addr, src_addr, src2_addr, immediate, jump_offset,
      input  ready
   );
   modport sink (
      input  valid, opcode, dest_addr, src_addr, src2_addr, immediate, jump_offset,
      output ready
   );
endinterface

interface mmae_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [mmae_pkg::STATUS_W-1:0]  status;
   logic signed [mmae_pkg::DATA_W-1:0]    print_value;
   logic        [mmae_pkg::DATA_W-1:0]    jump_target;

   modport source (
      output valid, status, print_value, jump_target,
      input  ready
   );
   modport sink (
      input  valid, status, print_value, jump_target,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/core/memory_to_memory_alu_executor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// memory_to_memory_alu_executor
// executes one decoded instruction per beat against a zero-cleared word ram
// sequence: pad, unused opcodes, jump, exit and address errors go from accept
//   straight to the finish state; other ops read x, and y too for two-read ops,
//   then run the shared alu, whose one-bit-per-cycle divider serves div and mod
// flow: one instruction at a time, the next accepted once the result is in the
//   output register; the result register lets it wait for rsp ready
// reset: synchronous; words_in_use returns to 1024 and the ram is cleared
//   one word per cycle before the first instruction
// ----------------------------------------------------------------------------
module memory_to_memory_alu_executor #(
   parameter  int MEM_WORDS = 1024,
   localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1,
   localparam int LIM_W     = 17
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mmae_req_if.sink                             req_bus,
   mmae_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [mmae_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [mmae_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [mmae_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_X,
      S_RD_Y,
      S_CAP_Y,
      S_EXEC,
      S_WAIT,
      S_FINISH
   } exec_state_type;

   localparam logic [LIM_W-1:0] MEM_LIM = LIM_W'(MEM_WORDS);

   function automatic logic addr_ok(input logic [mmae_pkg::ADDR_W-1:0] a,
                                    input logic [LIM_W-1:0] l);
      return LIM_W'(a) < l;
   endfunction

   exec_state_type                      state_ff, state_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   mmae_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic [mmae_pkg::DATA_W-1:0]         rsp_pval_ff, rsp_pval_in;
   logic [mmae_pkg::DATA_W-1:0]         rsp_jt_ff, rsp_jt_in;
   mmae_pkg::status_type                res_status_ff, res_status_in;
   logic [mmae_pkg::DATA_W-1:0]         res_pval_ff, res_pval_in;
   logic [mmae_pkg::DATA_W-1:0]         res_jt_ff, res_jt_in;
   logic [mmae_pkg::OPCODE_W-1:0]       op_ff, op_in;
   mmae_pkg::alu_func_type              func_ff, func_in;
   logic [mmae_pkg::ADDR_W-1:0]         d_ff, d_in;
   logic [mmae_pkg::ADDR_W-1:0]         x_addr_ff, x_addr_in;
   logic [mmae_pkg::ADDR_W-1:0]         y_addr_ff, y_addr_in;
   logic                                need_y_ff, need_y_in;
   logic [mmae_pkg::DATA_W-1:0]         x_ff, x_in;
   logic [mmae_pkg::DATA_W-1:0]         y_ff, y_in;
   logic [mmae_pkg::DATA_W-1:0]         joff_ff, joff_in;
   logic [mmae_pkg::WIU_W-1:0]          wiu_ff, wiu_in;
   logic [AW-1:0]                       clr_addr_ff, clr_addr_in;

   logic [LIM_W-1:0]                    lim;
   logic                                dec_need_d, dec_need_s, dec_need_s2;
   logic                                dec_mem, dec_x_is_s, dec_need_y, dec_y_from_s2;
   logic [mmae_pkg::DATA_W-1:0]         dec_y_const;
   mmae_pkg::status_type                dec_status;
   mmae_pkg::alu_func_type              dec_func;
   logic                                range_bad;
   logic                                csr_wr;

   logic                                ram_we;
   logic [AW-1:0]                       ram_waddr;
   logic [mmae_pkg::DATA_W-1:0]         ram_wdata;
   logic [AW-1:0]                       ram_raddr;
   logic [mmae_pkg::DATA_W-1:0]         ram_rdata;

   mmae_pkg::alu_cmd_type               alu_cmd;
   mmae_pkg::alu_sts_type               alu_sts;
   logic [mmae_pkg::DATA_W-1:0]         alu_result;

   mmae_ram #(
      .WIDTH (mmae_pkg::DATA_W),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   mmae_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .a      (x_ff),
      .b      (y_ff),
      .sts    (alu_sts),
      .result (alu_result)
   );

   // config port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite
                     & (csr_paddr[mmae_pkg::CSR_ADDR_W-1] == mmae_pkg::CSR_IDX_WORDS_IN_USE);
   assign csr_prdata = (csr_paddr[mmae_pkg::CSR_ADDR_W-1] == mmae_pkg::CSR_IDX_WORDS_IN_USE)
                     ? mmae_pkg::CSR_DATA_W'(wiu_ff) : '0;

   // usable limit is the smaller of words_in_use and the ram depth
   assign lim = (LIM_W'(wiu_ff) < MEM_LIM) ? LIM_W'(wiu_ff) : MEM_LIM;

   // instruction decode
   always_comb begin
      dec_need_d    = 1'b0;
      dec_need_s    = 1'b0;
      dec_need_s2   = 1'b0;
      dec_mem       = 1'b0;
      dec_x_is_s    = 1'b1;
      dec_need_y    = 1'b0;
      dec_y_from_s2 = 1'b0;
      dec_y_const   = $unsigned(req_bus.immediate);
      dec_status    = mmae_pkg::ST_DONE;
      dec_func      = mmae_pkg::FN_MOV;
      case (req_bus.opcode)
         mmae_pkg::OP_ADD_C, mmae_pkg::OP_SUB_C, mmae_pkg::OP_MUL_C,
         mmae_pkg::OP_DIV_C, mmae_pkg::OP_MOD_C, mmae_pkg::OP_MOV_C: begin
            dec_need_d = 1'b1;
            dec_mem    = 1'b1;
            dec_x_is_s = 1'b0;
         end
         mmae_pkg::OP_ADD_M, mmae_pkg::OP_SUB_M, mmae_pkg::OP_MUL_M,
         mmae_pkg::OP_DIV_M, mmae_pkg::OP_MOD_M, mmae_pkg::OP_MOV_M: begin
            dec_need_d = 1'b1;
            dec_need_s = 1'b1;
            dec_mem    = 1'b1;
            dec_x_is_s = 1'b0;
            dec_need_y = 1'b1;
         end
         mmae_pkg::OP_EQ_C: begin
            dec_need_d = 1'b1;
            dec_need_s = 1'b1;
            dec_mem    = 1'b1;
         end
         mmae_pkg::OP_EQ_M: begin
            dec_need_d    = 1'b1;
            dec_need_s    = 1'b1;
            dec_need_s2   = 1'b1;
            dec_mem       = 1'b1;
            dec_need_y    = 1'b1;
            dec_y_from_s2 = 1'b1;
         end
         mmae_pkg::OP_JMP: begin
            dec_status = mmae_pkg::ST_JUMP;
         end
         mmae_pkg::OP_JZ, mmae_pkg::OP_JNZ: begin
            dec_need_s  = 1'b1;
            dec_mem     = 1'b1;
            dec_y_const = '0;
         end
         mmae_pkg::OP_JEQ, mmae_pkg::OP_PRINT: begin
            dec_need_s = 1'b1;
            dec_mem    = 1'b1;
         end
         mmae_pkg::OP_EXIT: begin
            dec_status = mmae_pkg::ST_EXIT;
         end
         mmae_pkg::OP_PAD: begin
            dec_status = mmae_pkg::ST_DONE;
         end
         default: begin
            dec_status = mmae_pkg::ST_DONE;
         end
      endcase
      case (req_bus.opcode)
         mmae_pkg::OP_ADD_C, mmae_pkg::OP_ADD_M: dec_func = mmae_pkg::FN_ADD;
         mmae_pkg::OP_SUB_C, mmae_pkg::OP_SUB_M: dec_func = mmae_pkg::FN_SUB;
         mmae_pkg::OP_MUL_C, mmae_pkg::OP_MUL_M: dec_func = mmae_pkg::FN_MUL;
         mmae_pkg::OP_DIV_C, mmae_pkg::OP_DIV_M: dec_func = mmae_pkg::FN_DIV;
         mmae_pkg::OP_MOD_C, mmae_pkg::OP_MOD_M: dec_func = mmae_pkg::FN_MOD;
         mmae_pkg::OP_EQ_C, mmae_pkg::OP_EQ_M, mmae_pkg::OP_JZ,
         mmae_pkg::OP_JNZ, mmae_pkg::OP_JEQ:     dec_func = mmae_pkg::FN_EQ;
         default:                                dec_func = mmae_pkg::FN_MOV;
      endcase
   end

   assign range_bad = (dec_need_d  & ~addr_ok(req_bus.dest_addr, lim))
                    | (dec_need_s  & ~addr_ok(req_bus.src_addr, lim))
                    | (dec_need_s2 & ~addr_ok(req_bus.src2_addr, lim));

   assign req_bus.ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pval_in   = rsp_pval_ff;
      rsp_jt_in     = rsp_jt_ff;
      res_status_in = res_status_ff;
      res_pval_in   = res_pval_ff;
      res_jt_in     = res_jt_ff;
      op_in         = op_ff;
      func_in       = func_ff;
      d_in          = d_ff;
      x_addr_in     = x_addr_ff;
      y_addr_in     = y_addr_ff;
      need_y_in     = need_y_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      joff_in       = joff_ff;
      wiu_in        = csr_wr ? csr_pwdata[mmae_pkg::WIU_W-1:0] : wiu_ff;
      clr_addr_in   = clr_addr_ff;
      ram_we        = 1'b0;
      ram_waddr     = AW'(d_ff);
      ram_wdata     = alu_result;
      ram_raddr     = AW'(y_addr_ff);
      alu_cmd.start = 1'b0;
      alu_cmd.func  = func_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(MEM_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in       = req_bus.opcode;
               func_in     = dec_func;
               d_in        = req_bus.dest_addr;
               x_addr_in   = dec_x_is_s ? req_bus.src_addr : req_bus.dest_addr;
               y_addr_in   = dec_y_from_s2 ? req_bus.src2_addr : req_bus.src_addr;
               need_y_in   = dec_need_y;
               y_in        = dec_y_const;
               joff_in     = req_bus.jump_offset;
               res_pval_in = '0;
               res_jt_in   = (req_bus.opcode == mmae_pkg::OP_JMP) ? req_bus.jump_offset : '0;
               if (range_bad) begin
                  res_status_in = mmae_pkg::ST_RANGE;
                  state_in      = S_FINISH;
               end else if (dec_mem) begin
                  state_in = S_RD_X;
               end else begin
                  res_status_in = dec_status;
                  state_in      = S_FINISH;
               end
            end
         end
         S_RD_X: begin
            ram_raddr = AW'(x_addr_ff);
            state_in  = S_RD_Y;
         end
         S_RD_Y: begin
            x_in     = ram_rdata;
            state_in = need_y_ff ? S_CAP_Y : S_EXEC;
         end
         S_CAP_Y: begin
            y_in     = ram_rdata;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            alu_cmd.start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (alu_sts.done) begin
               res_status_in = mmae_pkg::ST_DONE;
               res_pval_in   = '0;
               res_jt_in     = '0;
               state_in      = S_FINISH;
               case (op_ff)
                  mmae_pkg::OP_JZ, mmae_pkg::OP_JEQ: begin
                     if (alu_result[0]) begin
                        res_status_in = mmae_pkg::ST_JUMP;
                        res_jt_in     = joff_ff;
                     end
                  end
                  mmae_pkg::OP_JNZ: begin
                     if (!alu_result[0]) begin
                        res_status_in = mmae_pkg::ST_JUMP;
                        res_jt_in     = joff_ff;
                     end
                  end
                  mmae_pkg::OP_PRINT: begin
                     res_status_in = mmae_pkg::ST_PRINT;
                     res_pval_in   = x_ff;
                  end
                  default: begin
                     if (alu_sts.div_zero) begin
                        res_status_in = mmae_pkg::ST_DIVZ;
                     end else begin
                        ram_we = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pval_in   = res_pval_ff;
               rsp_jt_in     = res_jt_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_pval_ff   <= rsp_pval_in;
      rsp_jt_ff     <= rsp_jt_in;
      res_status_ff <= res_status_in;
      res_pval_ff   <= res_pval_in;
      res_jt_ff     <= res_jt_in;
      op_ff         <= op_in;
      func_ff       <= func_in;
      d_ff          <= d_in;
      x_addr_ff     <= x_addr_in;
      y_addr_ff     <= y_addr_in;
      need_y_ff     <= need_y_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      joff_ff       <= joff_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         wiu_ff       <= mmae_pkg::WIU_RESET;
         clr_addr_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wiu_ff       <= wiu_in;
         clr_addr_ff  <= clr_addr_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.print_value = rsp_pval_ff;
   assign rsp_bus.jump_target = rsp_jt_ff;

`ifndef SYNTHESIS
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> state_ff == S_CLEAR)
      else $error("ram clear pass not started after reset");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != S_CLEAR) |-> addr_ok(d_ff, lim))
      else $error("ram written beyond usable limit");

   a_alu_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_sts.done |-> state_ff == S_WAIT)
      else $error("alu finished outside wait state");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && (!rsp_valid_ff || rsp_bus.ready))
      |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not loaded when output register was free");

   a_pval_only_print: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != mmae_pkg::ST_PRINT) |-> rsp_pval_ff == '0)
      else $error("print value set on a non-print result");
`endif

endmodule
`default_nettype wire

>>> rtl/core/mmae_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmae_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mmae_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 1024,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> rtl/core/mmae_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmae_alu
// shared arithmetic unit: registered add, sub, mul, move and compare,
// restoring divider at one quotient bit per cycle for div and mod
// ----------------------------------------------------------------------------
module mmae_alu (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mmae_pkg::alu_cmd_type       cmd,
   input  wire logic [mmae_pkg::DATA_W-1:0] a,
   input  wire logic [mmae_pkg::DATA_W-1:0] b,
   output mmae_pkg::alu_sts_type            sts,
   output logic      [mmae_pkg::DATA_W-1:0] result
);

   typedef enum logic [0:0] {
      A_IDLE,
      A_DIV
   } alu_state_type;

   alu_state_type                     state_ff, state_in;
   logic                              done_ff, done_in;
   logic                              dz_ff, dz_in;
   logic                              mod_ff, mod_in;
   logic [mmae_pkg::STEP_W-1:0]       cnt_ff, cnt_in;
   logic [mmae_pkg::DATA_W-1:0]       result_ff, result_in;
   logic [mmae_pkg::DATA_W-1:0]       quo_ff, quo_in;
   logic [mmae_pkg::DATA_W-1:0]       rem_ff, rem_in;
   logic [mmae_pkg::DATA_W-1:0]       dvs_ff, dvs_in;
   logic [mmae_pkg::DATA_W:0]         trial;
   logic [mmae_pkg::DATA_W-1:0]       step_rem;
   logic [mmae_pkg::DATA_W-1:0]       step_quo;

   assign trial    = {rem_ff, quo_ff[mmae_pkg::DATA_W-1]} - {1'b0, dvs_ff};
   assign step_rem = trial[mmae_pkg::DATA_W]
                   ? {rem_ff[mmae_pkg::DATA_W-2:0], quo_ff[mmae_pkg::DATA_W-1]}
                   : trial[mmae_pkg::DATA_W-1:0];
   assign step_quo = {quo_ff[mmae_pkg::DATA_W-2:0], ~trial[mmae_pkg::DATA_W]};

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      dz_in     = dz_ff;
      mod_in    = mod_ff;
      cnt_in    = cnt_ff;
      result_in = result_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               dz_in = 1'b0;
               case (cmd.func)
                  mmae_pkg::FN_ADD: begin
                     result_in = a + b;
                     done_in   = 1'b1;
                  end
                  mmae_pkg::FN_SUB: begin
                     result_in = a - b;
                     done_in   = 1'b1;
                  end
                  mmae_pkg::FN_MUL: begin
                     result_in = a * b;
                     done_in   = 1'b1;
                  end
                  mmae_pkg::FN_DIV, mmae_pkg::FN_MOD: begin
                     if (b == '0) begin
                        dz_in   = 1'b1;
                        done_in = 1'b1;
                     end else begin
                        state_in = A_DIV;
                        quo_in   = a;
                        rem_in   = '0;
                        dvs_in   = b;
                        cnt_in   = '0;
                        mod_in   = (cmd.func == mmae_pkg::FN_MOD);
                     end
                  end
                  mmae_pkg::FN_EQ: begin
                     result_in = {{(mmae_pkg::DATA_W-1){1'b0}}, (a == b)};
                     done_in   = 1'b1;
                  end
                  default: begin
                     result_in = b;
                     done_in   = 1'b1;
                  end
               endcase
            end
         end
         A_DIV: begin
            quo_in = step_quo;
            rem_in = step_rem;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mmae_pkg::STEP_W'(mmae_pkg::DATA_W - 1)) begin
               state_in  = A_IDLE;
               done_in   = 1'b1;
               result_in = mod_ff ? step_rem : step_quo;
            end
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dz_ff     <= dz_in;
      mod_ff    <= mod_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign sts.done     = done_ff;
   assign sts.div_zero = dz_ff;
   assign result       = result_ff;

endmodule
`default_nettype wire

>>> bench/memory_to_memory_alu_executor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// memory_to_memory_alu_executor_tb
// self-checking bench for the memory-to-memory alu executor: instruction
// beats go in through a valid/ready driver with random gaps, every accepted
// beat is executed on a shadow copy of the data memory and its expected
// result is queued, and result beats are compared field by field in order
// while the receiver stalls at random; words_in_use is rewritten between
// phases, including zero and the largest register value
// ----------------------------------------------------------------------------
module memory_to_memory_alu_executor_tb;

   localparam int MEM_WORDS = 1024;
   localparam logic [mmae_pkg::CSR_ADDR_W-1:0] WIU_ADDR =
      {mmae_pkg::CSR_IDX_WORDS_IN_USE, 2'b00};
   localparam logic [mmae_pkg::OPCODE_W-1:0] OP_UNUSED_LO = mmae_pkg::OP_EXIT + 5'd1;
   localparam logic [mmae_pkg::OPCODE_W-1:0] OP_UNUSED_HI = '1;
   localparam int SETTLE_CYCLES = 48;

   typedef struct packed {
      logic [mmae_pkg::OPCODE_W-1:0] opcode;
      logic [mmae_pkg::ADDR_W-1:0]   dest_addr;
      logic [mmae_pkg::ADDR_W-1:0]   src_addr;
      logic [mmae_pkg::ADDR_W-1:0]   src2_addr;
      logic [mmae_pkg::DATA_W-1:0]   immediate;
      logic [mmae_pkg::DATA_W-1:0]   jump_offset;
   } instruction_type;

   typedef struct packed {
      mmae_pkg::status_type          status;
      logic [mmae_pkg::DATA_W-1:0]   print_value;
      logic [mmae_pkg::DATA_W-1:0]   jump_target;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [mmae_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [mmae_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [mmae_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   mmae_req_if req_bus ();
   mmae_rsp_if rsp_bus ();

   memory_to_memory_alu_executor #(.MEM_WORDS(MEM_WORDS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [mmae_pkg::DATA_W-1:0] data_words [MEM_WORDS];
   logic [mmae_pkg::WIU_W-1:0]  words_in_use = mmae_pkg::WIU_RESET;

   instruction_type pending_instrs [$];
   outcome_type     expected_outcomes [$];
   instruction_type outgoing;
   outcome_type     awaited;

   int unsigned beats_in    = 0;
   int unsigned beats_out   = 0;
   int unsigned error_count = 0;
   int unsigned send_gap    = 0;
   int unsigned recv_gap    = 0;
   bit          send_burst  = 1'b0;
   bit          recv_burst  = 1'b0;
   logic        hold_off    = 1'b0;

   initial begin
      foreach (data_words[i]) data_words[i] = '0;
   end

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endfunction

   function automatic int unsigned usable_limit();
      return (words_in_use > MEM_WORDS) ? MEM_WORDS : words_in_use;
   endfunction

   function automatic bit addr_ok(logic [mmae_pkg::ADDR_W-1:0] a);
      return a < usable_limit();
   endfunction

   // executes one instruction on the shadow memory and returns its result
   function automatic outcome_type execute_instruction(instruction_type ins);
      outcome_type                 res;
      logic [mmae_pkg::DATA_W-1:0] lhs;
      logic [mmae_pkg::DATA_W-1:0] rhs;
      logic                        is_const;
      logic                        need_src;
      logic                        need_src2;
      logic                        taken;
      res.status      = mmae_pkg::ST_DONE;
      res.print_value = '0;
      res.jump_target = '0;
      is_const  = ins.opcode[0];
      need_src  = (!is_const && ins.opcode <= mmae_pkg::OP_MOV_M)
                  || ins.opcode >= mmae_pkg::OP_EQ_C;
      need_src2 = (ins.opcode == mmae_pkg::OP_EQ_M);
      if (ins.opcode >= mmae_pkg::OP_ADD_C && ins.opcode <= mmae_pkg::OP_EQ_M) begin
         if (!addr_ok(ins.dest_addr) || (need_src && !addr_ok(ins.src_addr))
             || (need_src2 && !addr_ok(ins.src2_addr))) begin
            res.status = mmae_pkg::ST_RANGE;
         end else if (ins.opcode >= mmae_pkg::OP_EQ_C) begin
            rhs = (ins.opcode == mmae_pkg::OP_EQ_C) ? ins.immediate
                                                    : data_words[ins.src2_addr];
            data_words[ins.dest_addr] = (data_words[ins.src_addr] == rhs) ? 32'd1 : 32'd0;
         end else begin
            rhs = is_const ? ins.immediate : data_words[ins.src_addr];
            lhs = data_words[ins.dest_addr];
            case (ins.opcode)
               mmae_pkg::OP_ADD_C, mmae_pkg::OP_ADD_M: lhs = lhs + rhs;
               mmae_pkg::OP_SUB_C, mmae_pkg::OP_SUB_M: lhs = lhs - rhs;
               mmae_pkg::OP_MUL_C, mmae_pkg::OP_MUL_M: lhs = lhs * rhs;
               mmae_pkg::OP_DIV_C, mmae_pkg::OP_DIV_M: begin
                  if (rhs == '0) res.status = mmae_pkg::ST_DIVZ;
                  else lhs = lhs / rhs;
               end
               mmae_pkg::OP_MOD_C, mmae_pkg::OP_MOD_M: begin
                  if (rhs == '0) res.status = mmae_pkg::ST_DIVZ;
                  else lhs = lhs % rhs;
               end
               default: lhs = rhs;
            endcase
            if (res.status == mmae_pkg::ST_DONE) data_words[ins.dest_addr] = lhs;
         end
      end else if (ins.opcode == mmae_pkg::OP_JMP) begin
         res.status      = mmae_pkg::ST_JUMP;
         res.jump_target = ins.jump_offset;
      end else if (ins.opcode >= mmae_pkg::OP_JZ && ins.opcode <= mmae_pkg::OP_JEQ) begin
         if (!addr_ok(ins.src_addr)) begin
            res.status = mmae_pkg::ST_RANGE;
         end else begin
            lhs = data_words[ins.src_addr];
            if (ins.opcode == mmae_pkg::OP_JZ) taken = (lhs == '0);
            else if (ins.opcode == mmae_pkg::OP_JNZ) taken = (lhs != '0);
            else taken = (lhs == ins.immediate);
            if (taken) begin
               res.status      = mmae_pkg::ST_JUMP;
               res.jump_target = ins.jump_offset;
            end
         end
      end else if (ins.opcode == mmae_pkg::OP_PRINT) begin
         if (!addr_ok(ins.src_addr)) begin
            res.status = mmae_pkg::ST_RANGE;
         end else begin
            res.status      = mmae_pkg::ST_PRINT;
            res.print_value = data_words[ins.src_addr];
         end
      end else if (ins.opcode == mmae_pkg::OP_EXIT) begin
         res.status = mmae_pkg::ST_EXIT;
      end
      return res;
   endfunction

   // mostly a few low words so that values build up, sometimes the edge of
   // the usable range, sometimes anywhere
   function automatic logic [mmae_pkg::ADDR_W-1:0] pick_addr();
      int unsigned r;
      int unsigned lim;
      int unsigned a;
      r   = $urandom_range(0, 9);
      lim = usable_limit();
      if (lim == 0 || r == 0) return mmae_pkg::ADDR_W'($urandom_range(0, MEM_WORDS - 1));
      if (r == 1) begin
         a = lim - 1 + $urandom_range(0, 1);
         if (a > MEM_WORDS - 1) a = MEM_WORDS - 1;
         return mmae_pkg::ADDR_W'(a);
      end
      return mmae_pkg::ADDR_W'($urandom_range(0, ((lim < 8) ? lim : 8) - 1));
   endfunction

   function automatic logic [mmae_pkg::DATA_W-1:0] pick_immediate();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 8) return mmae_pkg::DATA_W'($urandom_range(0, 7));
      if (r < 10) return '0 - mmae_pkg::DATA_W'($urandom_range(1, 4));
      if (r < 12) begin
         case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return '0;
         endcase
      end
      return $urandom();
   endfunction

   function automatic instruction_type random_instruction();
      instruction_type ins;
      int unsigned     r;
      r = $urandom_range(0, 99);
      if (r < 3) ins.opcode = mmae_pkg::OP_PAD;
      else if (r < 7)
         ins.opcode = mmae_pkg::OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else if (r < 17) ins.opcode = mmae_pkg::OP_MOV_C;
      else ins.opcode = mmae_pkg::OPCODE_W'($urandom_range(mmae_pkg::OP_ADD_C,
                                                           mmae_pkg::OP_EXIT));
      ins.dest_addr = pick_addr();
      ins.src_addr  = pick_addr();
      ins.src2_addr = pick_addr();
      ins.immediate = pick_immediate();
      r = $urandom_range(0, 9);
      ins.jump_offset = (r == 0) ? '0 : (r == 1) ? '1 : $urandom();
      return ins;
   endfunction

   task automatic push_instr(logic [mmae_pkg::OPCODE_W-1:0] op, int unsigned d,
                             int unsigned s, int unsigned s2,
                             logic [mmae_pkg::DATA_W-1:0] imm,
                             logic [mmae_pkg::DATA_W-1:0] joff);
      instruction_type ins;
      ins.opcode      = op;
      ins.dest_addr   = mmae_pkg::ADDR_W'(d);
      ins.src_addr    = mmae_pkg::ADDR_W'(s);
      ins.src2_addr   = mmae_pkg::ADDR_W'(s2);
      ins.immediate   = imm;
      ins.jump_offset = joff;
      pending_instrs.push_back(ins);
   endtask

   task automatic fill_random(int unsigned count);
      repeat (count) pending_instrs.push_back(random_instruction());
   endtask

   task automatic drain_all();
      do @(negedge clock);
      while (pending_instrs.size() != 0 || req_bus.valid || expected_outcomes.size() != 0);
   endtask

   task automatic write_words_in_use(logic [mmae_pkg::WIU_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= WIU_ADDR;
      csr_pwdata  <= mmae_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      words_in_use = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic start_phase(logic [mmae_pkg::WIU_W-1:0] value);
      drain_all();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_words_in_use(value);
      @(negedge clock);
   endtask

   // instruction driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap != 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_instrs.size() != 0) begin
            outgoing = pending_instrs.pop_front();
            req_bus.opcode      <= outgoing.opcode;
            req_bus.dest_addr   <= outgoing.dest_addr;
            req_bus.src_addr    <= outgoing.src_addr;
            req_bus.src2_addr   <= outgoing.src2_addr;
            req_bus.immediate   <= outgoing.immediate;
            req_bus.jump_offset <= outgoing.jump_offset;
            req_bus.valid       <= 1'b1;
            if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 9);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // accepted instruction beats feed the shadow executor
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         expected_outcomes.push_back(execute_instruction('{
            opcode:      req_bus.opcode,
            dest_addr:   req_bus.dest_addr,
            src_addr:    req_bus.src_addr,
            src2_addr:   req_bus.src2_addr,
            immediate:   req_bus.immediate,
            jump_offset: req_bus.jump_offset}));
         beats_in++;
      end
   end

   // result receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            beats_out++;
            if (expected_outcomes.size() == 0) begin
               flag_error($sformatf("result beat %0d with no instruction outstanding: %0d %0d %h",
                                    beats_out, rsp_bus.status, rsp_bus.print_value,
                                    rsp_bus.jump_target));
            end else begin
               awaited = expected_outcomes.pop_front();
               if (rsp_bus.status !== awaited.status
                   || rsp_bus.print_value !== awaited.print_value
                   || rsp_bus.jump_target !== awaited.jump_target)
                  flag_error($sformatf({"result beat %0d: expected status %0d print %0d ",
                                        "jump %h, got status %0d print %0d jump %h"},
                                       beats_out, awaited.status,
                                       $signed(awaited.print_value), awaited.jump_target,
                                       rsp_bus.status, rsp_bus.print_value,
                                       rsp_bus.jump_target));
            end
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            recv_gap = recv_burst ? 0 : $urandom_range(0, 9);
         end else if (recv_gap != 0) begin
            recv_gap--;
         end
         rsp_bus.ready <= !hold_off && recv_gap == 0;
      end
   end

   // long receiver stall while instructions keep coming
   initial begin
      while (beats_in < 120) @(negedge clock);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("[memory_to_memory_alu_executor] ERROR");
      $finish;
   end

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.opcode      = '0;
      req_bus.dest_addr   = '0;
      req_bus.src_addr    = '0;
      req_bus.src2_addr   = '0;
      req_bus.immediate   = '0;
      req_bus.jump_offset = '0;
      rsp_bus.ready       = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // full range: wraparound, divide by zero, compares, branches, print
      push_instr(mmae_pkg::OP_PAD,   0,    0,    0,    '0,            '0);
      push_instr(mmae_pkg::OP_MOV_C, 0,    0,    0,    32'h7FFF_FFFF, '0);
      push_instr(mmae_pkg::OP_MOV_C, 1023, 0,    0,    32'h8000_0000, '0);
      push_instr(mmae_pkg::OP_ADD_C, 0,    0,    0,    32'd1,         '0);
      push_instr(mmae_pkg::OP_PRINT, 0,    0,    0,    '0,            '0);
      push_instr(mmae_pkg::OP_ADD_M, 1023, 0,    0,    '0,            '0);
      push_instr(mmae_pkg::OP_SUB_C, 2,    0,    0,    32'd1,         '0);
      push_instr(mmae_pkg::OP_SUB_M, 3,    2,    0,    '0,            '0);
      push_instr(mmae_pkg::OP_MUL_C, 2,    0,    0,    32'hFFFF_FFFF, '0);
      push_instr(mmae_pkg::OP_MOV_C, 4,    0,    0,    32'd7,         '0);
      push_instr(mmae_pkg::OP_MUL_M, 4,    4,    0,    '0,            '0);
      push_instr(mmae_pkg::OP_DIV_C, 4,    0,    0,    '0,            '0);
      push_instr(mmae_pkg::OP_DIV_C, 4,    0,    0,    32'd5,         '0);
      push_instr(mmae_pkg::OP_DIV_M, 4,    5,    0,    '0,            '0);
      push_instr(mmae_pkg::OP_MOD_C, 4,    0,    0,    32'd4,         '0);
      push_instr(mmae_pkg::OP_MOD_M, 2,    4,    0,    '0,            '0);
      push_instr(mmae_pkg::OP_MOV_M, 6,    3,    0,    '0,            '0);
      push_instr(mmae_pkg::OP_EQ_C,  7,    3,    0,    32'd1,         '0);
      push_instr(mmae_pkg::OP_EQ_M,  1023, 1023, 1023, '0,            '0);
      push_instr(mmae_pkg::OP_JMP,   0,    0,    0,    '0,            32'hFFFF_FFFF);
      push_instr(mmae_pkg::OP_JZ,    0,    5,    0,    '0,            32'h10);
      push_instr(mmae_pkg::OP_JNZ,   0,    5,    0,    '0,            32'h20);
      push_instr(mmae_pkg::OP_JEQ,   0,    3,    0,    32'd1,         32'h1234);
      push_instr(mmae_pkg::OP_EXIT,  0,    0,    0,    '0,            '0);
      push_instr(OP_UNUSED_HI,       1023, 1023, 1023, '1,            '1);
      fill_random(500);

      start_phase(11'd1);
      fill_random(100);

      // no usable words at all
      start_phase(11'd0);
      push_instr(mmae_pkg::OP_MOV_C, 0, 0, 0, 32'd3, '0);
      push_instr(mmae_pkg::OP_JMP,   0, 0, 0, '0,    32'h40);
      push_instr(mmae_pkg::OP_PRINT, 0, 0, 0, '0,    '0);
      push_instr(mmae_pkg::OP_EXIT,  0, 0, 0, '0,    '0);
      fill_random(60);

      start_phase(11'd2047);
      fill_random(150);

      // range check ahead of divide by zero, jump without address check
      start_phase(11'd16);
      push_instr(mmae_pkg::OP_ADD_C, 16, 0,    0,  32'd1, '0);
      push_instr(mmae_pkg::OP_EQ_M,  0,  0,    16, '0,    '0);
      push_instr(mmae_pkg::OP_DIV_C, 20, 0,    0,  '0,    '0);
      push_instr(mmae_pkg::OP_JMP,   0,  1023, 0,  '0,    32'h80);
      push_instr(mmae_pkg::OP_JZ,    0,  16,   0,  '0,    32'h84);
      push_instr(mmae_pkg::OP_PRINT, 0,  15,   0,  '0,    '0);
      fill_random(300);

      repeat (3) begin
         start_phase(mmae_pkg::WIU_W'($urandom_range(1, MEM_WORDS)));
         fill_random(150);
      end

      start_phase(11'd1024);
      fill_random(250);

      drain_all();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_outcomes.size() != 0)
         flag_error($sformatf("%0d results never arrived", expected_outcomes.size()));
      if (error_count == 0) begin
         $display("[memory_to_memory_alu_executor] OK");
      end else begin
         $display("[memory_to_memory_alu_executor] ERROR");
      end
      $finish;
   end

endmodule
